// File: design/pca_pkg.sv
// Package for the presence confidence rate adapter.
// Holds the word types, register map, command and report codes and the
// fixed widths shared by the configuration block, the divider and the top level.
`default_nettype none

package pca_pkg;

    // Field widths fixed by the interface.
    localparam int SPACING_W = 16;
    localparam int LEVEL_W   = 8;
    localparam int STEP_W    = 6;
    localparam int TREND_W   = 26;
    localparam int COUNT_W   = 32;
    localparam int DIVISOR_W = 5;   // level / 10 is at most 25
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // level / 10 is taken as (level * 205) >> 11, exact for every 8-bit level.
    localparam logic [LEVEL_W-1:0] TENTH_RECIP = 8'd205;
    localparam int                 TENTH_SHIFT = 11;

    // Register indices (byte address is four times the index).
    localparam logic [2:0] REG_FRAME_SPACING = 3'd0;
    localparam logic [2:0] REG_MIN_SPACING   = 3'd1;
    localparam logic [2:0] REG_MAX_LEVEL     = 3'd2;
    localparam logic [2:0] REG_MIN_LEVEL     = 3'd3;
    localparam logic [2:0] REG_ACTIVE_LEVEL  = 3'd4;
    localparam logic [2:0] REG_INACTIVE_LVL  = 3'd5;
    localparam logic [2:0] REG_RISE_STEP     = 3'd6;
    localparam logic [2:0] REG_FALL_STEP     = 3'd7;

    // Register reset values.
    localparam logic [SPACING_W-1:0] RST_FRAME_SPACING = 16'd3000;
    localparam logic [SPACING_W-1:0] RST_MIN_SPACING   = 16'd750;
    localparam logic [LEVEL_W-1:0]   RST_MAX_LEVEL     = 8'd100;
    localparam logic [LEVEL_W-1:0]   RST_MIN_LEVEL     = 8'd10;
    localparam logic [LEVEL_W-1:0]   RST_ACTIVE_LEVEL  = 8'd80;
    localparam logic [LEVEL_W-1:0]   RST_INACTIVE_LVL  = 8'd20;
    localparam logic [STEP_W-1:0]    RST_RISE_STEP     = 6'd20;
    localparam logic [STEP_W-1:0]    RST_FALL_STEP     = 6'd5;

    // State reset values.
    localparam logic [LEVEL_W-1:0]   RST_LEVEL    = 8'd1;
    localparam logic [TREND_W-1:0]   RST_TREND    = 26'd256;
    localparam logic [SPACING_W-1:0] RST_INTERVAL = 16'd3000;

    // Commands.
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_ALIVE = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;

    // Report codes.
    localparam logic [1:0] REP_NONE     = 2'd0;
    localparam logic [1:0] REP_ACTIVE   = 2'd1;
    localparam logic [1:0] REP_INACTIVE = 2'd2;
    localparam logic [1:0] REP_ALIVE    = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       presence;
        logic       link_up;
    } t_in_word;

    typedef struct packed {
        logic [SPACING_W-1:0] interval_ms;
        logic                 interval_updated;
        logic [LEVEL_W-1:0]   level;
        logic [1:0]           report;
        logic [COUNT_W-1:0]   report_count;
    } t_out_word;

    typedef struct packed {
        logic [SPACING_W-1:0] frame_spacing_ms;
        logic [SPACING_W-1:0] min_spacing_ms;
        logic [LEVEL_W-1:0]   max_level;
        logic [LEVEL_W-1:0]   min_level;
        logic [LEVEL_W-1:0]   active_level;
        logic [LEVEL_W-1:0]   inactive_level;
        logic [STEP_W-1:0]    rise_step;
        logic [STEP_W-1:0]    fall_step;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: design/pca_cfg.sv
// Configuration register bank with an APB-style access port.
// Depends on pca_pkg for the register map, reset values and t_cfg.
`default_nettype none

module pca_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pca_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pca_pkg::DATA_W-1:0] pwdata,
    output logic      [pca_pkg::DATA_W-1:0] prdata,
    output pca_pkg::t_cfg                   o_cfg
);

    pca_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_spacing_ms <= pca_pkg::RST_FRAME_SPACING;
            r_cfg.min_spacing_ms   <= pca_pkg::RST_MIN_SPACING;
            r_cfg.max_level        <= pca_pkg::RST_MAX_LEVEL;
            r_cfg.min_level        <= pca_pkg::RST_MIN_LEVEL;
            r_cfg.active_level     <= pca_pkg::RST_ACTIVE_LEVEL;
            r_cfg.inactive_level   <= pca_pkg::RST_INACTIVE_LVL;
            r_cfg.rise_step        <= pca_pkg::RST_RISE_STEP;
            r_cfg.fall_step        <= pca_pkg::RST_FALL_STEP;
        end else if (wr_en) begin
            unique case (reg_idx)
                pca_pkg::REG_FRAME_SPACING: r_cfg.frame_spacing_ms <= pwdata[15:0];
                pca_pkg::REG_MIN_SPACING:   r_cfg.min_spacing_ms   <= pwdata[15:0];
                pca_pkg::REG_MAX_LEVEL:     r_cfg.max_level        <= pwdata[7:0];
                pca_pkg::REG_MIN_LEVEL:     r_cfg.min_level        <= pwdata[7:0];
                pca_pkg::REG_ACTIVE_LEVEL:  r_cfg.active_level     <= pwdata[7:0];
                pca_pkg::REG_INACTIVE_LVL:  r_cfg.inactive_level   <= pwdata[7:0];
                pca_pkg::REG_RISE_STEP:     r_cfg.rise_step        <= pwdata[5:0];
                pca_pkg::REG_FALL_STEP:     r_cfg.fall_step        <= pwdata[5:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pca_pkg::REG_FRAME_SPACING: prdata = {16'd0, r_cfg.frame_spacing_ms};
            pca_pkg::REG_MIN_SPACING:   prdata = {16'd0, r_cfg.min_spacing_ms};
            pca_pkg::REG_MAX_LEVEL:     prdata = {24'd0, r_cfg.max_level};
            pca_pkg::REG_MIN_LEVEL:     prdata = {24'd0, r_cfg.min_level};
            pca_pkg::REG_ACTIVE_LEVEL:  prdata = {24'd0, r_cfg.active_level};
            pca_pkg::REG_INACTIVE_LVL:  prdata = {24'd0, r_cfg.inactive_level};
            pca_pkg::REG_RISE_STEP:     prdata = {26'd0, r_cfg.rise_step};
            pca_pkg::REG_FALL_STEP:     prdata = {26'd0, r_cfg.fall_step};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/pca_divider.sv
// Restoring divider that produces one quotient bit per clock.
// Depends on pca_pkg for the default widths and the t_div_stat status type.
`default_nettype none

module pca_divider #(
    parameter int DIVIDEND_W = pca_pkg::SPACING_W,
    parameter int DIVISOR_W  = pca_pkg::DIVISOR_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output pca_pkg::t_div_stat         o_stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// File: design/presence_confidence_rate_adapter.sv
// Top level of the presence confidence rate adapter: sequencer, state and result register.
// Depends on pca_pkg, pca_cfg and pca_divider.
//
//  Channel   Direction  Handshake                 Word
//  input     in         i_in_valid / o_in_stall   pca_pkg::t_in_word
//  output    out        o_out_valid / i_out_stall pca_pkg::t_out_word
//  config    in         psel/penable/pwrite       APB, 32-bit data, 5-bit paddr
//
// A frame event that moves the level passes from evaluation through the divider start
// and divide states, where the 16 steps of the bit-serial divider run, to reporting.
// Other words go straight from evaluation to reporting. One word is in work at a time.
// The result register holds a finished word while the next word is taken in.
// Reset is synchronous and active low; it resets state and flags, not the data registers.
`default_nettype none

module presence_confidence_rate_adapter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire pca_pkg::t_in_word          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output pca_pkg::t_out_word              o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pca_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pca_pkg::DATA_W-1:0] pwdata,
    output logic      [pca_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DIVS   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    localparam int LW = pca_pkg::LEVEL_W;
    localparam int TW = pca_pkg::TREND_W;
    localparam int SW = pca_pkg::SPACING_W;
    localparam int CW = pca_pkg::COUNT_W;
    localparam int DW = pca_pkg::DIVISOR_W;

    pca_pkg::t_cfg      cfg;
    pca_pkg::t_div_stat div_stat;
    logic [SW-1:0]      div_quo;

    logic [2:0]         r_state, n_state;
    pca_pkg::t_in_word  r_in;
    logic [LW-1:0]      r_level, n_level;
    logic [TW-1:0]      r_trend, n_trend;
    logic [SW-1:0]      r_interval, n_interval;
    logic               r_act, n_act;
    logic               r_inact, n_inact;
    logic               r_needs, n_needs;
    logic               r_alive, n_alive;
    logic [CW-1:0]      r_count, n_count;
    logic               r_upd, n_upd;
    logic               r_down, n_down;
    logic               r_out_valid, n_out_valid;
    pca_pkg::t_out_word r_out_data, n_out_data;

    logic               in_accept;
    logic               out_free;
    logic               div_start;
    logic [DW-1:0]      divisor;
    logic [15:0]        tenth_prod;
    logic [DW-1:0]      tens;
    logic [LW:0]        level_up;
    logic [TW:0]        trend_sum;
    logic [TW-1:0]      trend_mid;
    logic               trend_pos;
    logic               load_out;
    logic [1:0]         rep;

    pca_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    pca_divider #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cfg.frame_spacing_ms),
        .i_divisor  (divisor),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign div_start  = (r_state == ST_DIVS);

    // Divisor is max(1, level / 10), with level / 10 by reciprocal multiply.
    assign tenth_prod = 16'(r_level) * 16'(pca_pkg::TENTH_RECIP);
    assign tens       = tenth_prod[pca_pkg::TENTH_SHIFT +: DW];
    assign divisor    = (tens == '0) ? DW'(1) : tens;

    assign level_up  = {1'b0, r_level} + (LW+1)'(r_in.presence ? cfg.rise_step : '0);
    assign trend_pos = !r_trend[TW-1] && (r_trend != '0);

    // The quotient enters the trend as d * 256, i.e. shifted left by eight.
    assign trend_sum = r_down ? ({r_trend[TW-1], r_trend} - (TW+1)'({div_quo, 8'd0}))
                              : ({r_trend[TW-1], r_trend} + (TW+1)'({div_quo, 8'd0}));
    assign trend_mid = trend_sum[TW:1];

    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_trend    = r_trend;
        n_interval = r_interval;
        n_act      = r_act;
        n_inact    = r_inact;
        n_needs    = r_needs;
        n_alive    = r_alive;
        n_count    = r_count;
        n_upd      = r_upd;
        n_down     = r_down;
        load_out   = 1'b0;
        rep        = pca_pkg::REP_NONE;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EVAL;
                    n_upd   = 1'b0;
                end
            end
            ST_EVAL: begin
                n_state = ST_REPORT;
                if (r_in.command == pca_pkg::CMD_FRAME) begin
                    if (r_in.presence && r_level >= cfg.max_level) begin
                        n_trend = {r_trend[TW-1], r_trend[TW-1:1]};
                        n_level = cfg.max_level;
                    end else if (r_in.presence) begin
                        if (r_level >= cfg.active_level && trend_pos) begin
                            n_act = 1'b1;
                        end
                        n_level = level_up[LW] ? '1 : level_up[LW-1:0];
                        n_down  = 1'b0;
                        n_upd   = 1'b1;
                        n_state = ST_DIVS;
                    end else if (r_level > cfg.min_level) begin
                        if (r_level == cfg.inactive_level && r_trend[TW-1] && r_needs) begin
                            n_inact = 1'b1;
                        end
                        n_level = (r_level > LW'(cfg.fall_step))
                                ? r_level - LW'(cfg.fall_step) : '0;
                        n_down  = 1'b1;
                        n_upd   = 1'b1;
                        n_state = ST_DIVS;
                    end else begin
                        // Already at or below the floor: settle on it.
                        n_trend = {r_trend[TW-1], r_trend[TW-1:1]};
                        n_level = cfg.min_level;
                    end
                end else if (r_in.command == pca_pkg::CMD_ALIVE) begin
                    n_alive = 1'b1;
                end
            end
            ST_DIVS: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state    = ST_REPORT;
                    n_interval = (div_quo > cfg.min_spacing_ms) ? div_quo
                                                                : cfg.min_spacing_ms;
                    // A fall that reaches the floor halves the trend once more.
                    if (r_down && r_level <= cfg.min_level) begin
                        n_trend = {trend_mid[TW-1], trend_mid[TW-1:1]};
                        n_level = cfg.min_level;
                    end else begin
                        n_trend = trend_mid;
                    end
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_in.link_up && ((r_act && !r_needs) || r_inact)) begin
                        n_count = r_count + 1'b1;
                        if (r_inact) begin
                            n_needs = 1'b0;
                            n_act   = 1'b0;
                            n_inact = 1'b0;
                            rep     = pca_pkg::REP_INACTIVE;
                        end else begin
                            n_needs = 1'b1;
                            n_act   = 1'b0;
                            rep     = pca_pkg::REP_ACTIVE;
                        end
                    end else if (r_in.link_up && r_alive) begin
                        n_alive = 1'b0;
                        n_count = r_count + 1'b1;
                        rep     = pca_pkg::REP_ALIVE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_data                  = r_out_data;
        n_out_valid                 = r_out_valid && i_out_stall;
        if (load_out) begin
            n_out_valid                 = 1'b1;
            n_out_data.interval_ms      = r_interval;
            n_out_data.interval_updated = r_upd;
            n_out_data.level            = r_level;
            n_out_data.report           = rep;
            n_out_data.report_count     = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= pca_pkg::RST_LEVEL;
            r_trend     <= pca_pkg::RST_TREND;
            r_interval  <= pca_pkg::RST_INTERVAL;
            r_act       <= 1'b0;
            r_inact     <= 1'b0;
            r_needs     <= 1'b0;
            r_alive     <= 1'b0;
            r_count     <= '0;
            r_upd       <= 1'b0;
            r_down      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_trend     <= n_trend;
            r_interval  <= n_interval;
            r_act       <= n_act;
            r_inact     <= n_inact;
            r_needs     <= n_needs;
            r_alive     <= n_alive;
            r_count     <= n_count;
            r_upd       <= n_upd;
            r_down      <= n_down;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || div_stat.done) |-> (r_state == ST_DIV))
        else $error("divider active outside the divide state");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EVAL))
        else $error("accepted word did not enter evaluation");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && rep != pca_pkg::REP_NONE) |=> (r_count == $past(r_count) + 1'b1))
        else $error("report count did not advance with a sent report");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load_out && rep != pca_pkg::REP_NONE) |=> $stable(r_count))
        else $error("report count moved without a sent report");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for presence_confidence_rate_adapter: directed and random event words,
// a confidence predictor kept in step with the block, and a field-by-field output check.
// Depends on pca_pkg and the RTL of the block; reads no files.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pca_pkg::*;

    // The spare command code behaves as a plain poll.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RESULT_LATENCY = 25;
    localparam int PHASE_EVENTS = 116;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_word            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_word           o_out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    presence_confidence_rate_adapter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register copy and predicted block state, starting from their reset values.
    t_cfg cfg_mirror = '{RST_FRAME_SPACING, RST_MIN_SPACING, RST_MAX_LEVEL, RST_MIN_LEVEL,
                         RST_ACTIVE_LEVEL, RST_INACTIVE_LVL, RST_RISE_STEP, RST_FALL_STEP};
    logic [LEVEL_W-1:0]   conf_level = RST_LEVEL;
    int                   trend_q8 = int'(RST_TREND);
    logic [SPACING_W-1:0] interval_now = RST_INTERVAL;
    logic                 active_due = 1'b0;
    logic                 inactive_due = 1'b0;
    logic                 needs_inactive = 1'b0;
    logic                 alive_due = 1'b0;
    logic [COUNT_W-1:0]   reports_sent = '0;

    t_in_word    events_to_send[$];
    t_out_word   due_outputs[$];
    int unsigned words_offered = 0;
    int unsigned words_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned interval_moves = 0;
    int unsigned active_seen = 0;
    int unsigned inactive_seen = 0;
    int unsigned alive_seen = 0;
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 88;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          presence_run = 1'b0;

    function automatic int reprogram_interval();
        int divisor;
        int spaced;
        divisor = conf_level / 10;
        if (divisor == 0) begin
            divisor = 1;
        end
        spaced = cfg_mirror.frame_spacing_ms / divisor;
        interval_now = (spaced > cfg_mirror.min_spacing_ms) ? spaced[SPACING_W-1:0]
                                                            : cfg_mirror.min_spacing_ms;
        return spaced;
    endfunction

    // Moves the confidence state on by one event word and returns the word the block owes.
    function automatic t_out_word advance_confidence(t_in_word ev);
        t_out_word          res;
        logic [LEVEL_W:0]   raised;
        int                 delay_ms;
        logic               updated;
        logic [1:0]         rep;
        updated = 1'b0;
        rep = REP_NONE;
        if (ev.command == CMD_FRAME) begin
            if (ev.presence && conf_level >= cfg_mirror.max_level) begin
                trend_q8 = trend_q8 >>> 1;
                conf_level = cfg_mirror.max_level;
            end else if (ev.presence) begin
                if (conf_level >= cfg_mirror.active_level && trend_q8 > 0) begin
                    active_due = 1'b1;
                end
                raised = conf_level + cfg_mirror.rise_step;
                conf_level = raised[LEVEL_W] ? {LEVEL_W{1'b1}} : raised[LEVEL_W-1:0];
                delay_ms = reprogram_interval();
                trend_q8 = (trend_q8 + delay_ms * 256) >>> 1;
                updated = 1'b1;
            end else begin
                if (conf_level > cfg_mirror.min_level) begin
                    if (conf_level == cfg_mirror.inactive_level && trend_q8 < 0
                            && needs_inactive) begin
                        inactive_due = 1'b1;
                    end
                    conf_level = (conf_level > cfg_mirror.fall_step)
                                 ? conf_level - cfg_mirror.fall_step : '0;
                    delay_ms = reprogram_interval();
                    trend_q8 = (trend_q8 - delay_ms * 256) >>> 1;
                    updated = 1'b1;
                end
                if (conf_level <= cfg_mirror.min_level) begin
                    trend_q8 = trend_q8 >>> 1;
                    conf_level = cfg_mirror.min_level;
                end
            end
        end else if (ev.command == CMD_ALIVE) begin
            alive_due = 1'b1;
        end

        // Threshold reports take priority over the keep-alive.
        if (ev.link_up && ((active_due && !needs_inactive) || inactive_due)) begin
            reports_sent++;
            if (inactive_due) begin
                needs_inactive = 1'b0;
                active_due = 1'b0;
                inactive_due = 1'b0;
                rep = REP_INACTIVE;
            end else begin
                needs_inactive = 1'b1;
                active_due = 1'b0;
                rep = REP_ACTIVE;
            end
        end else if (ev.link_up && alive_due) begin
            alive_due = 1'b0;
            reports_sent++;
            rep = REP_ALIVE;
        end

        res.interval_ms = interval_now;
        res.interval_updated = updated;
        res.level = conf_level;
        res.report = rep;
        res.report_count = reports_sent;
        return res;
    endfunction

    function automatic t_in_word make_event(logic [1:0] cmd, logic pres, logic link);
        t_in_word ev;
        ev.command = cmd;
        ev.presence = pres;
        ev.link_up = link;
        return ev;
    endfunction

    // Presence comes in long runs so that the level climbs and falls through the thresholds.
    function automatic t_in_word random_event();
        t_in_word ev;
        int       pick;
        if ($urandom_range(7) == 0) begin
            presence_run = ~presence_run;
        end
        pick = $urandom_range(99);
        ev.command = (pick < 65) ? CMD_FRAME : (pick < 80) ? CMD_ALIVE
                   : (pick < 92) ? CMD_POLL : CMD_SPARE;
        ev.presence = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : presence_run;
        ev.link_up = ($urandom_range(99) < 75);
        return ev;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FRAME_SPACING: cfg_mirror.frame_spacing_ms = value[SPACING_W-1:0];
            REG_MIN_SPACING:   cfg_mirror.min_spacing_ms = value[SPACING_W-1:0];
            REG_MAX_LEVEL:     cfg_mirror.max_level = value[LEVEL_W-1:0];
            REG_MIN_LEVEL:     cfg_mirror.min_level = value[LEVEL_W-1:0];
            REG_ACTIVE_LEVEL:  cfg_mirror.active_level = value[LEVEL_W-1:0];
            REG_INACTIVE_LVL:  cfg_mirror.inactive_level = value[LEVEL_W-1:0];
            REG_RISE_STEP:     cfg_mirror.rise_step = value[STEP_W-1:0];
            REG_FALL_STEP:     cfg_mirror.fall_step = value[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(int spacing, int min_sp, int max_l, int min_l,
                                 int act_l, int inact_l, int rise, int fall);
        write_register(REG_FRAME_SPACING, spacing);
        write_register(REG_MIN_SPACING, min_sp);
        write_register(REG_MAX_LEVEL, max_l);
        write_register(REG_MIN_LEVEL, min_l);
        write_register(REG_ACTIVE_LEVEL, act_l);
        write_register(REG_INACTIVE_LVL, inact_l);
        write_register(REG_RISE_STEP, rise);
        write_register(REG_FALL_STEP, fall);
    endtask

    // Holds the sender back until every owed word is out and the block has gone quiet.
    task automatic wait_drained();
        while (events_to_send.size() != 0 || words_taken != words_offered
                || due_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    // Sender: a new word is offered only once the one on the bus has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || words_taken == words_offered) begin
            if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= events_to_send.pop_front();
                i_in_valid <= 1'b1;
                words_offered++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            due_outputs.push_back(advance_confidence(i_in_data));
            words_taken++;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_outputs.size() == 0) begin
                mismatches++;
                $display("%0t ns: output word %h arrived with none expected",
                         $time, o_out_data);
            end else begin
                want = due_outputs.pop_front();
                check_field("interval_ms", want.interval_ms, o_out_data.interval_ms);
                check_field("interval_updated", want.interval_updated,
                            o_out_data.interval_updated);
                check_field("level", want.level, o_out_data.level);
                check_field("report", want.report, o_out_data.report);
                check_field("report_count", want.report_count, o_out_data.report_count);
                interval_moves += want.interval_updated;
                case (want.report)
                    REP_ACTIVE:   active_seen++;
                    REP_INACTIVE: inactive_seen++;
                    REP_ALIVE:    alive_seen++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        #7_200_000;
        $display("presence_confidence_rate_adapter: mismatch");
        $finish;
    end

    initial begin
        int unsigned phase;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: a floor of zero and a large fall step reach the inactive level
        // and the level range where the divisor would be zero.
        apply_setting(3000, 750, 100, 0, 80, 20, 20, 20);
        events_to_send.push_back(make_event(CMD_POLL, 1'b0, 1'b0));
        events_to_send.push_back(make_event(CMD_ALIVE, 1'b0, 1'b0));
        events_to_send.push_back(make_event(CMD_SPARE, 1'b1, 1'b1));
        events_to_send.push_back(make_event(CMD_FRAME, 1'b0, 1'b0));
        repeat (6) events_to_send.push_back(make_event(CMD_FRAME, 1'b1, 1'b0));
        events_to_send.push_back(make_event(CMD_POLL, 1'b0, 1'b1));
        repeat (6) events_to_send.push_back(make_event(CMD_FRAME, 1'b0, 1'b1));
        events_to_send.push_back(make_event(CMD_ALIVE, 1'b0, 1'b1));
        events_to_send.push_back(make_event(CMD_ALIVE, 1'b1, 1'b0));
        events_to_send.push_back(make_event(CMD_FRAME, 1'b1, 1'b1));
        wait_drained();

        for (phase = 1; phase <= 8; phase++) begin
            if (phase <= 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 88;
            end else if (phase <= 5) begin
                send_idle_pct = 88;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1: apply_setting(65535, 65535, 200, 0, 255, 255, 55, 55);
                2: apply_setting(1, 0, 1, 0, 0, 0, 0, 0);
                3: apply_setting(1200, 100, 30, 60, 40, 50, 7, 3);
                // A ceiling at the top of the register lets a rise saturate the level.
                4: apply_setting(40000, 500, 255, 5, 150, 200, 55, 9);
                5: apply_setting(3000, 200, 100, 10, 30, 40, 10, 5);
                7: apply_setting(3000, 750, 100, 10, 80, 20, 20, 5);
                default: apply_setting($urandom_range(65535, 1), $urandom_range(2000),
                                       $urandom_range(200, 1), $urandom_range(60),
                                       $urandom_range(255), $urandom_range(200),
                                       $urandom_range(55), $urandom_range(55));
            endcase
            repeat (PHASE_EVENTS) events_to_send.push_back(random_event());
            wait_drained();
        end

        if (due_outputs.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d expected words never arrived", $time, due_outputs.size());
        end
        $display("Checked %0d output words over nine register settings; %0d moved the interval.",
                 results_seen, interval_moves);
        $display("Reports seen: %0d active, %0d inactive, %0d keep-alive.",
                 active_seen, inactive_seen, alive_seen);
        if (mismatches == 0) begin
            $display("presence_confidence_rate_adapter: match");
        end else begin
            $display("presence_confidence_rate_adapter: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
